>>> src/chm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chained hash map package
// Shared widths and operation and status codes for the hash map engine.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int MaxBinBits = 10;
  localparam int PoolDepth = 1024;
  localparam int ValueWidth = 64;
  localparam int BinSlots = 1 << MaxBinBits;
  localparam int IdxW = $clog2(PoolDepth);
  localparam int LinkW = IdxW + 1;
  localparam int BinW = MaxBinBits;
  localparam int KeyW = 32;
  localparam int MinBinBits = 3;

  localparam logic [LinkW-1:0] NullLink = LinkW'(PoolDepth);

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

endpackage

`default_nettype wire

>>> src/chained_hash_map_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chained hash map engine
// Key to value map with separate chaining over a bounded entry pool.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. busy falls in the
// cycle in which the single result is shown on the out_ ports with out_valid,
// so the next request can be taken at the edge that ends that cycle. The
// receiver cannot stall. After reset the block first sweeps the bin head and
// free stack memories, one entry per cycle, with busy high.
// A request then passes HEAD and HEADW, then ENT and ENTW per chain entry
// visited, set by the single read port of the entry memories, then DONE. A
// miss also passes FREE, and an insert of a new key FREEW for the free stack
// and link updates. An unknown operation goes from IDLE straight to DONE.
module chained_hash_map_engine import chm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_operation,
  input  wire logic signed [31:0]    in_key,
  input  wire logic [63:0]           in_value_in,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [63:0]                out_value_out,
  output logic [10:0]                out_entry_count,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [3:0]            cfg_bin_index_bits
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HEAD, S_HEADW, S_ENT, S_ENTW, S_FREE, S_FREEW, S_DONE
  } state_t;

  state_t              state_r;
  logic [3:0]          bib_r;
  logic [1:0]          op_r;
  logic [KeyW-1:0]     key_r;
  logic [ValueWidth-1:0] val_r;
  logic [BinW-1:0]     bin_r;
  logic [LinkW-1:0]    cur_r, prev_r, head_r;
  logic [LinkW-1:0]    steps_r;
  logic [LinkW-1:0]    free_top_r;
  logic [10:0]         count_r;
  logic [BinW:0]       clr_r;
  logic [1:0]          status_r;
  logic [63:0]         vout_r;
  logic                out_valid_r;

  // Memories.
  logic [LinkW-1:0]      head_mem [BinSlots];
  logic [LinkW-1:0]      head_q;
  logic [KeyW-1:0]       key_mem  [PoolDepth];
  logic [ValueWidth-1:0] val_mem  [PoolDepth];
  logic [LinkW-1:0]      link_mem [PoolDepth];
  logic [KeyW-1:0]       key_q;
  logic [ValueWidth-1:0] val_q;
  logic [LinkW-1:0]      link_q;
  logic [IdxW-1:0]       free_mem [PoolDepth];
  logic [IdxW-1:0]       free_q;

  logic                  head_we, ent_re, ent_kwe, ent_vwe, ent_lwe, free_we;
  logic [BinW-1:0]       head_wa;
  logic [LinkW-1:0]      head_wd;
  logic [IdxW-1:0]       ent_a, free_wa, free_ra;
  logic [LinkW-1:0]      link_wd;
  logic [IdxW-1:0]       free_wd;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_q <= head_mem[bin_r];
  end

  always_ff @(posedge clk) begin
    if (ent_kwe) key_mem[ent_a] <= key_r;
    if (ent_vwe) val_mem[ent_a] <= val_r;
    if (ent_lwe) link_mem[ent_a] <= link_wd;
    if (ent_re) begin
      key_q  <= key_mem[ent_a];
      val_q  <= val_mem[ent_a];
      link_q <= link_mem[ent_a];
    end
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    free_q <= free_mem[free_ra];
  end

  // Effective bin width and bin of the request key.
  logic [3:0]      bits_eff;
  logic [BinW-1:0] bin_c;
  always_comb begin
    bits_eff = bib_r;
    if (bits_eff < 4'(MinBinBits)) bits_eff = 4'(MinBinBits);
    if (bits_eff > 4'(MaxBinBits)) bits_eff = 4'(MaxBinBits);
    bin_c = in_key[BinW-1:0] & BinW'((32'd1 << bits_eff) - 32'd1);
  end

  logic hit;
  logic walk_end;
  assign hit      = (key_q == key_r);
  assign walk_end = (link_q >= NullLink) || (steps_r + 1'b1 >= LinkW'(PoolDepth));

  // Memory control, decided from the present state.
  always_comb begin
    head_we = 1'b0; head_wa = bin_r; head_wd = NullLink;
    ent_re = 1'b0; ent_kwe = 1'b0; ent_vwe = 1'b0; ent_lwe = 1'b0;
    ent_a = cur_r[IdxW-1:0]; link_wd = link_q;
    free_we = 1'b0; free_wa = free_top_r[IdxW-1:0]; free_wd = cur_r[IdxW-1:0];
    free_ra = IdxW'(free_top_r - 1'b1);
    unique case (state_r)
      S_CLEAR: begin
        head_we = 1'b1; head_wa = clr_r[BinW-1:0];
        free_we = 1'b1; free_wa = clr_r[IdxW-1:0];
        free_wd = IdxW'(LinkW'(PoolDepth - 1) - LinkW'(clr_r));
      end
      S_HEADW: begin
        ent_re = (head_q < NullLink); ent_a = head_q[IdxW-1:0];
      end
      S_ENTW: begin
        if (!hit && !walk_end) begin
          ent_re = 1'b1; ent_a = link_q[IdxW-1:0];
        end else if (hit) begin
          unique case (op_r)
            OP_INSERT: ent_vwe = 1'b1;
            OP_REMOVE: begin
              if (prev_r == NullLink) begin
                head_we = 1'b1; head_wd = link_q;
              end else begin
                ent_lwe = 1'b1; ent_a = prev_r[IdxW-1:0];
              end
              free_we = (free_top_r < LinkW'(PoolDepth));
            end
            default: ;
          endcase
        end
      end
      S_FREEW: begin
        ent_a = free_q; ent_kwe = 1'b1; ent_vwe = 1'b1; ent_lwe = 1'b1;
        link_wd = head_r;
        head_we = 1'b1; head_wd = LinkW'(free_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; bib_r <= 4'd10;
      free_top_r <= LinkW'(PoolDepth); count_r <= '0; out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) bib_r <= cfg_bin_index_bits;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (BinW+1)'(BinSlots - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (start) begin
          op_r <= in_operation; key_r <= in_key; val_r <= in_value_in;
          bin_r <= bin_c; prev_r <= NullLink; steps_r <= '0;
          status_r <= ST_NOTFOUND; vout_r <= '0;
          state_r <= (op_t'(in_operation) == OP_NONE) ? S_DONE : S_HEAD;
        end
        S_HEAD: state_r <= S_HEADW;
        S_HEADW: begin
          head_r <= head_q; cur_r <= head_q;
          state_r <= (head_q < NullLink) ? S_ENT : S_FREE;
        end
        S_ENT: state_r <= S_ENTW;
        S_ENTW: begin
          if (hit) begin
            status_r <= ST_DONE;
            state_r <= S_DONE;
            if (op_r == OP_FIND) vout_r <= 64'(val_q);
            if (op_r == OP_REMOVE) begin
              vout_r <= 64'(val_q);
              if (free_top_r < LinkW'(PoolDepth)) free_top_r <= free_top_r + 1'b1;
              if (count_r != '0) count_r <= count_r - 1'b1;
            end
          end else if (walk_end) begin
            state_r <= S_FREE;
          end else begin
            prev_r <= cur_r; cur_r <= link_q; steps_r <= steps_r + 1'b1;
            state_r <= S_ENT;
          end
        end
        S_FREE: begin
          if (op_r != OP_INSERT) state_r <= S_DONE;
          else if (free_top_r == '0) begin
            status_r <= ST_FULL; state_r <= S_DONE;
          end else state_r <= S_FREEW;
        end
        S_FREEW: begin
          free_top_r <= free_top_r - 1'b1; count_r <= count_r + 1'b1;
          status_r <= ST_DONE; state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid_r <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Nothing is taken while reset is held.
  assign busy            = !rst_n || (state_r != S_IDLE);
  assign cfg_ready       = rst_n;
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_value_out   = vout_r;
  assign out_entry_count = count_r;

  a_count_le_pool: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 11'(PoolDepth)) else $error("entry count exceeds pool");
  a_pool_balance: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_CLEAR |-> (32'(count_r) + 32'(free_top_r) == PoolDepth))
    else $error("free pool and entry count disagree");
  a_result_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DONE)) else $error("stray result");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash map engine testbench
// Drives find, insert and remove requests into the engine, tracks the map in
// a local copy of bins, entries and free pool, and checks every result's
// status, value and entry count against that copy. The bin count is changed
// between phases, also while entries are stored.
// ----------------------------------------------------------------------------
module tb;
  import chm_pkg::*;

  localparam int WatchLimit = 20000;

  typedef struct {
    status_t     status;
    logic [63:0] value;
    logic [10:0] count;
  } map_answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_operation = '0;
  logic signed [31:0] in_key = '0;
  logic [63:0] in_value_in = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [63:0] out_value_out;
  logic [10:0] out_entry_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_bin_index_bits = '0;

  chained_hash_map_engine u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_key(in_key), .in_value_in(in_value_in),
    .out_valid(out_valid), .out_status(out_status), .out_value_out(out_value_out),
    .out_entry_count(out_entry_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_bin_index_bits(cfg_bin_index_bits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the map.
  logic [LinkW-1:0] head_of_bin [BinSlots];
  logic [31:0]      slot_key    [PoolDepth];
  logic [63:0]      slot_value  [PoolDepth];
  logic [LinkW-1:0] slot_link   [PoolDepth];
  logic [IdxW-1:0]  free_slots  [PoolDepth];
  int               free_depth;
  int               stored;
  logic [3:0]       bin_bits_reg;

  map_answer_t answers_due [$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int full_answers = 0;
  int burst_left = 0;
  int quiet_cycles = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic int bin_for(input logic [31:0] key);
    int bits;
    bits = bin_bits_reg;
    if (bits < MinBinBits) bits = MinBinBits;
    if (bits > MaxBinBits) bits = MaxBinBits;
    return int'(key & ((32'd1 << bits) - 32'd1));
  endfunction

  // Applies one request to the local map and returns what the engine must answer.
  function automatic map_answer_t apply_request(input op_t op, input logic [31:0] key,
                                                input logic [63:0] value);
    map_answer_t ans;
    int bin, cur, prev, hit, steps, e;
    bin = bin_for(key);
    cur = head_of_bin[bin];
    prev = PoolDepth;
    hit = PoolDepth;
    steps = 0;
    while (cur < PoolDepth && steps < PoolDepth) begin
      if (slot_key[cur] == key) begin
        hit = cur;
        break;
      end
      prev = cur;
      cur = slot_link[cur];
      steps++;
    end
    if (hit == PoolDepth) prev = PoolDepth;
    ans.status = ST_NOTFOUND;
    ans.value = '0;
    case (op)
      OP_FIND: begin
        if (hit != PoolDepth) begin
          ans.status = ST_DONE;
          ans.value = slot_value[hit];
        end
      end
      OP_INSERT: begin
        if (hit != PoolDepth) begin
          slot_value[hit] = value;
          ans.status = ST_DONE;
        end else if (free_depth == 0) begin
          ans.status = ST_FULL;
        end else begin
          free_depth--;
          e = free_slots[free_depth];
          slot_key[e] = key;
          slot_value[e] = value;
          slot_link[e] = head_of_bin[bin];
          head_of_bin[bin] = LinkW'(e);
          stored++;
          ans.status = ST_DONE;
        end
      end
      OP_REMOVE: begin
        if (hit != PoolDepth) begin
          if (prev == PoolDepth) head_of_bin[bin] = slot_link[hit];
          else slot_link[prev] = slot_link[hit];
          ans.value = slot_value[hit];
          if (free_depth < PoolDepth) begin
            free_slots[free_depth] = IdxW'(hit);
            free_depth++;
          end
          if (stored > 0) stored--;
          ans.status = ST_DONE;
        end
      end
      default: ;
    endcase
    ans.count = 11'(stored);
    return ans;
  endfunction

  task automatic send_request(input op_t op, input logic [31:0] key,
                              input logic [63:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      // Mostly short bursts, with an occasional long run without gaps.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    @(negedge clk);
    start <= 1'b1;
    in_operation <= op;
    in_key <= key;
    in_value_in <= value;
    do @(posedge clk); while (busy);
    answers_due.push_back(apply_request(op, key, value));
    items_sent++;
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    burst_left = 0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_bin_bits(input logic [3:0] bits);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_bin_index_bits <= bits;
    do @(posedge clk); while (!cfg_ready);
    bin_bits_reg = bits;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (answers_due.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        map_answer_t want;
        want = answers_due.pop_front();
        if (out_status != want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
        if (out_value_out != want.value)
          report_mismatch($sformatf("value %h, expected %h", out_value_out, want.value));
        if (out_entry_count != want.count)
          report_mismatch($sformatf("entry count %0d, expected %0d",
                                    out_entry_count, want.count));
        if (want.status == ST_FULL) full_answers++;
      end
      results_seen++;
    end
  end

  // Watchdog: the engine must keep accepting something.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("Watchdog expired with %0d results outstanding", answers_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] any_value();
    return {$urandom, $urandom};
  endfunction

  task automatic test_basic_ops;
    send_request(OP_FIND, 32'd5, '0);
    send_request(OP_REMOVE, 32'd5, '0);
    send_request(OP_INSERT, 32'h0000_0000, 64'h0);
    send_request(OP_INSERT, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_INSERT, 32'h7FFF_FFFF, 64'h8000_0000_0000_0001);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 64'h5555_AAAA_5555_AAAA);
    send_request(OP_FIND, 32'h8000_0000, 64'h1234);
    send_request(OP_FIND, 32'hFFFF_FFFF, '0);
    // Replace keeps the entry count.
    send_request(OP_INSERT, 32'h7FFF_FFFF, 64'hAAAA_5555_AAAA_5555);
    send_request(OP_FIND, 32'h7FFF_FFFF, '0);
    // Four keys in bin zero: remove from the middle, then the head.
    send_request(OP_INSERT, 32'd1024, 64'd11);
    send_request(OP_INSERT, 32'd2048, 64'd22);
    send_request(OP_REMOVE, 32'd1024, '0);
    send_request(OP_REMOVE, 32'd2048, '0);
    send_request(OP_FIND, 32'd0, '0);
    send_request(OP_NONE, 32'd0, 64'hFFFF);
    send_request(OP_REMOVE, 32'h8000_0000, '0);
    send_request(OP_REMOVE, 32'h8000_0000, '0);
  endtask

  task automatic test_pool_full;
    for (int i = 0; i < PoolDepth; i++) send_request(OP_INSERT, 32'(i), any_value());
    send_request(OP_INSERT, 32'h0001_0000, any_value());
    send_request(OP_INSERT, 32'hDEAD_BEEF, any_value());
    send_request(OP_INSERT, 32'd17, any_value());
    send_request(OP_FIND, 32'd17, '0);
  endtask

  task automatic test_random_phase(input logic [3:0] bits, input int count);
    int pick;
    logic [31:0] key;
    op_t op;
    write_bin_bits(bits);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) key = $urandom_range(0, 1023);
      else if (pick < 70) key = $urandom_range(0, 31) | ($urandom_range(0, 3) << 10);
      else if (pick < 80) begin
        case ($urandom_range(0, 3))
          0: key = 32'h8000_0000;
          1: key = 32'h7FFF_FFFF;
          2: key = 32'hFFFF_FFFF;
          default: key = 32'h0;
        endcase
      end else key = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 45) op = OP_REMOVE;
      else if (pick < 77) op = OP_INSERT;
      else if (pick < 97) op = OP_FIND;
      else op = OP_NONE;
      send_request(op, key, any_value());
      if (n == count / 2 && bits == 4'd0) drain();
    end
  endtask

  initial begin
    for (int i = 0; i < BinSlots; i++) head_of_bin[i] = NullLink;
    for (int i = 0; i < PoolDepth; i++) begin
      slot_key[i] = '0;
      slot_value[i] = '0;
      slot_link[i] = '0;
      free_slots[i] = IdxW'(PoolDepth - 1 - i);
    end
    free_depth = PoolDepth;
    stored = 0;
    bin_bits_reg = 4'd10;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_pool_full();
    test_random_phase(4'd10, 150);
    test_random_phase(4'd3, 150);
    test_random_phase(4'd0, 150);
    test_random_phase(4'd15, 150);
    test_random_phase(4'd6, 150);

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests and checked %0d results, %0d of them pool-full.",
             items_sent, results_seen, full_answers);
    $display("Bin widths 10, 3, 0, 15 and 6 were used, changed with entries stored.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
